[src/psg_pkg.sv]
// Shared types, constants, command codes and microcode for the particle spawn generator.
`default_nettype none
package psg_pkg;

   localparam int MAX_BURST = 64;

   localparam logic [63:0] GOLDEN  = 64'h9E37_79B9_7F4A_7C15;
   localparam logic [63:0] MIX_C1  = 64'hBF58_476D_1CE4_E5B9;
   localparam logic [63:0] MIX_C2  = 64'h94D0_49BB_1331_11EB;
   localparam logic [49:0] NEAR_ZERO_SQ = 50'd281;

   // Shape modes.
   localparam logic [1:0] MODE_POINT  = 2'd0;
   localparam logic [1:0] MODE_BOX    = 2'd1;
   localparam logic [1:0] MODE_SPHERE = 2'd2;
   localparam logic [1:0] MODE_CONE   = 2'd3;

   // Register indexes.
   localparam logic [3:0] REG_SHAPE_MODE  = 4'd0;
   localparam logic [3:0] REG_ORIGIN_XYZ  = 4'd1;
   localparam logic [3:0] REG_EXTENT_XYZ  = 4'd2;
   localparam logic [3:0] REG_SPEED_MIN   = 4'd3;
   localparam logic [3:0] REG_SPEED_MAX   = 4'd4;
   localparam logic [3:0] REG_LIFE_MIN    = 4'd5;
   localparam logic [3:0] REG_LIFE_MAX    = 4'd6;
   localparam logic [3:0] REG_START_COLOR = 4'd7;

   // Datapath operations.
   localparam logic [4:0] OP_NOP        = 5'd0;
   localparam logic [4:0] OP_LOAD       = 5'd1;
   localparam logic [4:0] OP_RNG_STEP   = 5'd2;
   localparam logic [4:0] OP_ACC_LD     = 5'd3;
   localparam logic [4:0] OP_ACC_ADD    = 5'd4;
   localparam logic [4:0] OP_MIX_MID    = 5'd5;
   localparam logic [4:0] OP_DRAW_DONE  = 5'd6;
   localparam logic [4:0] OP_LD_ST      = 5'd7;
   localparam logic [4:0] OP_POS        = 5'd8;
   localparam logic [4:0] OP_SV         = 5'd9;
   localparam logic [4:0] OP_LIFE       = 5'd10;
   localparam logic [4:0] OP_L2_LD      = 5'd11;
   localparam logic [4:0] OP_L2_ADD     = 5'd12;
   localparam logic [4:0] OP_SQRT_START = 5'd13;
   localparam logic [4:0] OP_DIV_START  = 5'd14;
   localparam logic [4:0] OP_EMIT       = 5'd15;
   // Only seen by the controller: expands into a random draw sequence.
   localparam logic [4:0] OP_DRAW       = 5'd16;

   // Multiplier operand selections.
   localparam logic [4:0] M_Z_C1_LL = 5'd0;
   localparam logic [4:0] M_Z_C1_LH = 5'd1;
   localparam logic [4:0] M_Z_C1_HL = 5'd2;
   localparam logic [4:0] M_Z_C2_LL = 5'd3;
   localparam logic [4:0] M_Z_C2_LH = 5'd4;
   localparam logic [4:0] M_Z_C2_HL = 5'd5;
   localparam logic [4:0] M_SX_T    = 5'd6;
   localparam logic [4:0] M_SZ_T    = 5'd7;
   localparam logic [4:0] M_POS_X   = 5'd8;
   localparam logic [4:0] M_POS_Y   = 5'd9;
   localparam logic [4:0] M_POS_Z   = 5'd10;
   localparam logic [4:0] M_SPEED   = 5'd11;
   localparam logic [4:0] M_LIFE    = 5'd12;
   localparam logic [4:0] M_VX_VX   = 5'd13;
   localparam logic [4:0] M_VY_VY   = 5'd14;
   localparam logic [4:0] M_VZ_VZ   = 5'd15;
   localparam logic [4:0] M_VX_SV   = 5'd16;
   localparam logic [4:0] M_VY_SV   = 5'd17;
   localparam logic [4:0] M_VZ_SV   = 5'd18;

   // Draw targets.
   localparam logic [3:0] D_SX = 4'd0;
   localparam logic [3:0] D_SY = 4'd1;
   localparam logic [3:0] D_SZ = 4'd2;
   localparam logic [3:0] D_T  = 4'd3;
   localparam logic [3:0] D_U  = 4'd4;
   localparam logic [3:0] D_VX = 4'd5;
   localparam logic [3:0] D_VY = 4'd6;
   localparam logic [3:0] D_VZ = 4'd7;

   // Axes.
   localparam logic [3:0] AX_X = 4'd0;
   localparam logic [3:0] AX_Y = 4'd1;
   localparam logic [3:0] AX_Z = 4'd2;

   localparam logic [5:0] PC_LAST   = 6'd36;
   localparam logic [3:0] DRAW_LAST = 4'd8;

   typedef struct packed {
      logic [4:0] op;
      logic       mul_en;
      logic [4:0] mul_sel;
      logic [3:0] dst;
      logic       last;
   } dp_cmd_type;

   typedef struct packed {
      logic cone;
      logic near_zero;
      logic unit_done;
      logic out_free;
   } dp_stat_type;

   typedef struct packed {
      dp_cmd_type cmd;
      logic       cone_only;
   } ucode_type;

   function automatic logic [15:0] sat16(input logic signed [17:0] v);
      logic [15:0] r;
      if (v > 18'sd32767) begin
         r = 16'h7FFF;
      end else if (v < -18'sd32768) begin
         r = 16'h8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   // One particle's program.
   function automatic ucode_type ucode(input logic [5:0] pc);
      ucode_type u;
      u = '0;
      case (pc)
         6'd0:  begin u.cmd.op = OP_DRAW; u.cmd.dst = D_SX; end
         6'd1:  begin u.cmd.op = OP_DRAW; u.cmd.dst = D_SY; end
         6'd2:  begin u.cmd.op = OP_DRAW; u.cmd.dst = D_SZ; end
         6'd3:  begin u.cmd.op = OP_DRAW; u.cmd.dst = D_T; u.cone_only = 1'b1; end
         6'd4:  begin u.cmd.mul_en = 1'b1; u.cmd.mul_sel = M_SX_T; u.cone_only = 1'b1; end
         6'd5:  begin u.cmd.op = OP_LD_ST; u.cone_only = 1'b1; end
         6'd6:  begin u.cmd.mul_en = 1'b1; u.cmd.mul_sel = M_POS_X; end
         6'd7:  begin u.cmd.op = OP_POS; u.cmd.dst = AX_X; end
         6'd8:  begin u.cmd.mul_en = 1'b1; u.cmd.mul_sel = M_POS_Y; end
         6'd9:  begin u.cmd.op = OP_POS; u.cmd.dst = AX_Y; end
         6'd10: begin u.cmd.mul_en = 1'b1; u.cmd.mul_sel = M_SZ_T; u.cone_only = 1'b1; end
         6'd11: begin u.cmd.op = OP_LD_ST; u.cone_only = 1'b1; end
         6'd12: begin u.cmd.mul_en = 1'b1; u.cmd.mul_sel = M_POS_Z; end
         6'd13: begin u.cmd.op = OP_POS; u.cmd.dst = AX_Z; end
         6'd14: begin u.cmd.op = OP_DRAW; u.cmd.dst = D_U; end
         6'd15: begin u.cmd.mul_en = 1'b1; u.cmd.mul_sel = M_SPEED; end
         6'd16: begin u.cmd.op = OP_SV; end
         6'd17: begin u.cmd.op = OP_DRAW; u.cmd.dst = D_VX; end
         6'd18: begin u.cmd.op = OP_DRAW; u.cmd.dst = D_VY; end
         6'd19: begin u.cmd.op = OP_DRAW; u.cmd.dst = D_VZ; end
         6'd20: begin u.cmd.mul_en = 1'b1; u.cmd.mul_sel = M_VX_VX; end
         6'd21: begin u.cmd.op = OP_L2_LD; end
         6'd22: begin u.cmd.mul_en = 1'b1; u.cmd.mul_sel = M_VY_VY; end
         6'd23: begin u.cmd.op = OP_L2_ADD; end
         6'd24: begin u.cmd.mul_en = 1'b1; u.cmd.mul_sel = M_VZ_VZ; end
         6'd25: begin u.cmd.op = OP_L2_ADD; end
         6'd26: begin u.cmd.op = OP_SQRT_START; end
         6'd27: begin u.cmd.mul_en = 1'b1; u.cmd.mul_sel = M_VX_SV; end
         6'd28: begin u.cmd.op = OP_DIV_START; u.cmd.dst = AX_X; end
         6'd29: begin u.cmd.mul_en = 1'b1; u.cmd.mul_sel = M_VY_SV; end
         6'd30: begin u.cmd.op = OP_DIV_START; u.cmd.dst = AX_Y; end
         6'd31: begin u.cmd.mul_en = 1'b1; u.cmd.mul_sel = M_VZ_SV; end
         6'd32: begin u.cmd.op = OP_DIV_START; u.cmd.dst = AX_Z; end
         6'd33: begin u.cmd.op = OP_DRAW; u.cmd.dst = D_U; end
         6'd34: begin u.cmd.mul_en = 1'b1; u.cmd.mul_sel = M_LIFE; end
         6'd35: begin u.cmd.op = OP_LIFE; end
         6'd36: begin u.cmd.op = OP_EMIT; end
         default: begin u = '0; end
      endcase
      return u;
   endfunction

   // One SplitMix64 draw: add, two 64-bit multiplies from 32-bit partial products, final mix.
   function automatic dp_cmd_type draw_cmd(input logic [3:0] ds, input logic [3:0] dst);
      dp_cmd_type c;
      c = '0;
      case (ds)
         4'd0: begin c.op = OP_RNG_STEP; end
         4'd1: begin c.mul_en = 1'b1; c.mul_sel = M_Z_C1_LL; end
         4'd2: begin c.op = OP_ACC_LD; c.mul_en = 1'b1; c.mul_sel = M_Z_C1_LH; end
         4'd3: begin c.op = OP_ACC_ADD; c.mul_en = 1'b1; c.mul_sel = M_Z_C1_HL; end
         4'd4: begin c.op = OP_MIX_MID; end
         4'd5: begin c.mul_en = 1'b1; c.mul_sel = M_Z_C2_LL; end
         4'd6: begin c.op = OP_ACC_LD; c.mul_en = 1'b1; c.mul_sel = M_Z_C2_LH; end
         4'd7: begin c.op = OP_ACC_ADD; c.mul_en = 1'b1; c.mul_sel = M_Z_C2_HL; end
         4'd8: begin c.op = OP_DRAW_DONE; c.dst = dst; end
         default: begin c = '0; end
      endcase
      return c;
   endfunction

endpackage
`default_nettype wire

[src/psg_sqrt.sv]
// Iterative integer square root, two radicand bits per cycle.
`default_nettype none
module psg_sqrt (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [49:0] radicand,
   output logic             done,
   output logic [24:0]      root
);
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [49:0] x_ff, x_in;
   logic [26:0] rem_ff, rem_in;
   logic [24:0] root_ff, root_in;
   logic [26:0] rem_sh;
   logic [26:0] trial;

   always_comb begin
      rem_sh  = {rem_ff[24:0], x_ff[49:48]};
      trial   = {root_ff, 2'b01};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      x_in    = x_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         x_in    = radicand;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         x_in = {x_ff[47:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[23:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[23:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd24) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      x_ff    <= x_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;
endmodule
`default_nettype wire

[src/psg_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none
module psg_div (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [39:0] numer,
   input  wire logic [24:0] denom,
   output logic             done,
   output logic [39:0]      quot
);
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [39:0] q_ff, q_in;
   logic [25:0] rem_ff, rem_in;
   logic [24:0] den_ff, den_in;
   logic [25:0] rem_sh;

   always_comb begin
      rem_sh  = {rem_ff[24:0], q_ff[39]};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         q_in    = numer;
         rem_in  = '0;
         den_in  = denom;
      end else if (busy_ff) begin
         if (rem_sh >= {1'b0, den_ff}) begin
            rem_in = rem_sh - {1'b0, den_ff};
            q_in   = {q_ff[38:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            q_in   = {q_ff[38:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd39) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      q_ff   <= q_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quot = q_ff;
endmodule
`default_nettype wire

[src/psg_dp.sv]
// Datapath: configuration registers, generator, shared multiplier, root and divide units, result word.
`default_nettype none
module psg_dp (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire psg_pkg::dp_cmd_type  cmd,
   output psg_pkg::dp_stat_type      stat,
   input  wire logic [63:0]          seed,
   input  wire logic                 csr_valid,
   input  wire logic [3:0]           csr_index,
   input  wire logic [47:0]          csr_data,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [143:0]              rsp_tdata,
   output logic                      rsp_tlast
);
   // Configuration.
   logic [1:0]  mode_ff, mode_in;
   logic [47:0] origin_ff, origin_in;
   logic [47:0] extent_ff, extent_in;
   logic [15:0] smin_ff, smin_in, smax_ff, smax_in;
   logic [15:0] lmin_ff, lmin_in, lmax_ff, lmax_in;
   logic [31:0] color_ff, color_in;
   // Work registers.
   logic [63:0] emitted_ff, emitted_in;
   logic [63:0] rng_ff, rng_in;
   logic [63:0] z_ff, z_in;
   logic [63:0] m_ff, m_in;
   logic signed [65:0] prod_ff, prod_in;
   logic signed [24:0] sx_ff, sx_in, sy_ff, sy_in, sz_ff, sz_in;
   logic signed [24:0] vx_ff, vx_in, vy_ff, vy_in, vz_ff, vz_in;
   logic signed [24:0] st_ff, st_in;
   logic [23:0] t_ff, t_in, u_ff, u_in;
   logic [15:0] sv_ff, sv_in;
   logic [49:0] len2_ff, len2_in;
   logic [24:0] vlen_ff, vlen_in;
   logic [15:0] pos_x_ff, pos_x_in, pos_y_ff, pos_y_in, pos_z_ff, pos_z_in;
   logic [15:0] vel_x_ff, vel_x_in, vel_y_ff, vel_y_in, vel_z_ff, vel_z_in;
   logic [15:0] life_ff, life_in;
   logic [3:0]  div_axis_ff, div_axis_in;
   logic        div_neg_ff, div_neg_in;
   logic [143:0] out_data_ff, out_data_in;
   logic        out_last_ff, out_last_in;
   logic        out_valid_ff, out_valid_in;

   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] mul_p;
   logic [63:0] r_add, acc_sum, draw_word;
   logic [23:0] d_unit;
   logic signed [24:0] d_sgn;
   logic signed [16:0] off17;
   logic signed [15:0] org_lane;
   logic signed [17:0] pos_sum, sv_sum, life_sum;
   logic signed [16:0] sdiff, ldiff;
   logic signed [40:0] div_n;
   logic [39:0] div_mag;
   logic        sqrt_start, sqrt_done, div_start, div_done;
   logic [24:0] sqrt_root;
   logic [39:0] div_q, neg_q;
   logic [15:0] vel_val;
   logic signed [15:0] ex, ey, ez;

   assign ex = signed'(extent_ff[15:0]);
   assign ey = signed'(extent_ff[31:16]);
   assign ez = signed'(extent_ff[47:32]);

   // Shared multiplier, registered before any use.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (cmd.mul_sel)
         psg_pkg::M_Z_C1_LL: begin mul_a = {1'b0, z_ff[31:0]};  mul_b = {1'b0, psg_pkg::MIX_C1[31:0]}; end
         psg_pkg::M_Z_C1_LH: begin mul_a = {1'b0, z_ff[31:0]};  mul_b = {1'b0, psg_pkg::MIX_C1[63:32]}; end
         psg_pkg::M_Z_C1_HL: begin mul_a = {1'b0, z_ff[63:32]}; mul_b = {1'b0, psg_pkg::MIX_C1[31:0]}; end
         psg_pkg::M_Z_C2_LL: begin mul_a = {1'b0, z_ff[31:0]};  mul_b = {1'b0, psg_pkg::MIX_C2[31:0]}; end
         psg_pkg::M_Z_C2_LH: begin mul_a = {1'b0, z_ff[31:0]};  mul_b = {1'b0, psg_pkg::MIX_C2[63:32]}; end
         psg_pkg::M_Z_C2_HL: begin mul_a = {1'b0, z_ff[63:32]}; mul_b = {1'b0, psg_pkg::MIX_C2[31:0]}; end
         psg_pkg::M_SX_T: begin mul_a = 33'(sx_ff); mul_b = {9'd0, t_ff}; end
         psg_pkg::M_SZ_T: begin mul_a = 33'(sz_ff); mul_b = {9'd0, t_ff}; end
         psg_pkg::M_POS_X: begin
            mul_a = (mode_ff == psg_pkg::MODE_CONE) ? 33'(st_ff) : 33'(sx_ff);
            mul_b = 33'(ex);
         end
         psg_pkg::M_POS_Y: begin
            mul_a = (mode_ff == psg_pkg::MODE_CONE) ? {9'd0, t_ff} : 33'(sy_ff);
            mul_b = (mode_ff == psg_pkg::MODE_SPHERE) ? 33'(ex) : 33'(ey);
         end
         psg_pkg::M_POS_Z: begin
            mul_a = (mode_ff == psg_pkg::MODE_CONE) ? 33'(st_ff) : 33'(sz_ff);
            mul_b = (mode_ff == psg_pkg::MODE_BOX) ? 33'(ez) : 33'(ex);
         end
         psg_pkg::M_SPEED: begin mul_a = 33'(sdiff); mul_b = {9'd0, u_ff}; end
         psg_pkg::M_LIFE:  begin mul_a = 33'(ldiff); mul_b = {9'd0, u_ff}; end
         psg_pkg::M_VX_VX: begin mul_a = 33'(vx_ff); mul_b = 33'(vx_ff); end
         psg_pkg::M_VY_VY: begin mul_a = 33'(vy_ff); mul_b = 33'(vy_ff); end
         psg_pkg::M_VZ_VZ: begin mul_a = 33'(vz_ff); mul_b = 33'(vz_ff); end
         psg_pkg::M_VX_SV: begin mul_a = 33'(vx_ff); mul_b = {17'd0, sv_ff}; end
         psg_pkg::M_VY_SV: begin mul_a = 33'(vy_ff); mul_b = {17'd0, sv_ff}; end
         psg_pkg::M_VZ_SV: begin mul_a = 33'(vz_ff); mul_b = {17'd0, sv_ff}; end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   assign r_add     = rng_ff + psg_pkg::GOLDEN;
   assign acc_sum   = m_ff + {prod_ff[31:0], 32'd0};
   assign draw_word = acc_sum ^ (acc_sum >> 31);
   assign d_unit    = draw_word[63:40];
   // Twice the unit value minus one, as a signed fraction.
   assign d_sgn     = signed'({~draw_word[63], draw_word[62:40], 1'b0});
   // Floor of the product over 2^24.
   assign off17     = signed'(prod_ff[40:24]);
   assign sdiff     = signed'({1'b0, smax_ff}) - signed'({1'b0, smin_ff});
   assign ldiff     = signed'({1'b0, lmax_ff}) - signed'({1'b0, lmin_ff});
   assign sv_sum    = 18'(signed'({1'b0, smin_ff})) + 18'(off17);
   assign life_sum  = 18'(signed'({1'b0, lmin_ff})) + 18'(off17);
   assign div_n     = signed'(prod_ff[40:0]);
   assign div_mag   = div_n[40] ? 40'(-div_n) : div_n[39:0];
   assign neg_q     = -div_q;

   always_comb begin
      case (cmd.dst)
         psg_pkg::AX_Y: org_lane = signed'(origin_ff[31:16]);
         psg_pkg::AX_Z: org_lane = signed'(origin_ff[47:32]);
         default:       org_lane = signed'(origin_ff[15:0]);
      endcase
      if (mode_ff == psg_pkg::MODE_POINT) begin
         pos_sum = 18'(org_lane);
      end else begin
         pos_sum = 18'(org_lane) + 18'(off17);
      end
      if (div_neg_ff) begin
         vel_val = (div_q > 40'd32768) ? 16'h8000 : neg_q[15:0];
      end else begin
         vel_val = (div_q > 40'd32767) ? 16'h7FFF : div_q[15:0];
      end
   end

   assign sqrt_start = (cmd.op == psg_pkg::OP_SQRT_START);
   assign div_start  = (cmd.op == psg_pkg::OP_DIV_START) && (len2_ff > psg_pkg::NEAR_ZERO_SQ);

   psg_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (len2_ff),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   psg_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (div_mag),
      .denom (vlen_ff),
      .done  (div_done),
      .quot  (div_q)
   );

   always_comb begin
      mode_in     = mode_ff;
      origin_in   = origin_ff;
      extent_in   = extent_ff;
      smin_in     = smin_ff;
      smax_in     = smax_ff;
      lmin_in     = lmin_ff;
      lmax_in     = lmax_ff;
      color_in    = color_ff;
      emitted_in  = emitted_ff;
      rng_in      = rng_ff;
      z_in        = z_ff;
      m_in        = m_ff;
      prod_in     = cmd.mul_en ? mul_p : prod_ff;
      sx_in       = sx_ff;
      sy_in       = sy_ff;
      sz_in       = sz_ff;
      vx_in       = vx_ff;
      vy_in       = vy_ff;
      vz_in       = vz_ff;
      st_in       = st_ff;
      t_in        = t_ff;
      u_in        = u_ff;
      sv_in       = sv_ff;
      len2_in     = len2_ff;
      vlen_in     = sqrt_done ? sqrt_root : vlen_ff;
      pos_x_in    = pos_x_ff;
      pos_y_in    = pos_y_ff;
      pos_z_in    = pos_z_ff;
      vel_x_in    = vel_x_ff;
      vel_y_in    = vel_y_ff;
      vel_z_in    = vel_z_ff;
      life_in     = life_ff;
      div_axis_in = div_axis_ff;
      div_neg_in  = div_neg_ff;
      out_data_in = out_data_ff;
      out_last_in = out_last_ff;
      out_valid_in = (out_valid_ff && !rsp_tready) ? 1'b1 : 1'b0;

      if (csr_valid) begin
         unique case (csr_index)
            psg_pkg::REG_SHAPE_MODE:  mode_in   = csr_data[1:0];
            psg_pkg::REG_ORIGIN_XYZ:  origin_in = csr_data;
            psg_pkg::REG_EXTENT_XYZ:  extent_in = csr_data;
            psg_pkg::REG_SPEED_MIN:   smin_in   = csr_data[15:0];
            psg_pkg::REG_SPEED_MAX:   smax_in   = csr_data[15:0];
            psg_pkg::REG_LIFE_MIN:    lmin_in   = csr_data[15:0];
            psg_pkg::REG_LIFE_MAX:    lmax_in   = csr_data[15:0];
            psg_pkg::REG_START_COLOR: color_in  = csr_data[31:0];
            default: begin end
         endcase
      end

      if (div_done) begin
         case (div_axis_ff)
            psg_pkg::AX_Y: vel_y_in = vel_val;
            psg_pkg::AX_Z: vel_z_in = vel_val;
            default:       vel_x_in = vel_val;
         endcase
      end

      unique case (cmd.op)
         psg_pkg::OP_LOAD: rng_in = seed ^ emitted_ff;
         psg_pkg::OP_RNG_STEP: begin
            rng_in = r_add;
            z_in   = r_add ^ (r_add >> 30);
         end
         psg_pkg::OP_ACC_LD:  m_in = prod_ff[63:0];
         psg_pkg::OP_ACC_ADD: m_in = acc_sum;
         psg_pkg::OP_MIX_MID: z_in = acc_sum ^ (acc_sum >> 27);
         psg_pkg::OP_DRAW_DONE: begin
            case (cmd.dst)
               psg_pkg::D_SX: sx_in = d_sgn;
               psg_pkg::D_SY: sy_in = d_sgn;
               psg_pkg::D_SZ: sz_in = d_sgn;
               psg_pkg::D_T:  t_in  = d_unit;
               psg_pkg::D_VX: vx_in = d_sgn;
               psg_pkg::D_VY: vy_in = d_sgn;
               psg_pkg::D_VZ: vz_in = d_sgn;
               default:       u_in  = d_unit;
            endcase
         end
         psg_pkg::OP_LD_ST: st_in = signed'(prod_ff[48:24]);
         psg_pkg::OP_POS: begin
            case (cmd.dst)
               psg_pkg::AX_Y: pos_y_in = psg_pkg::sat16(pos_sum);
               psg_pkg::AX_Z: pos_z_in = psg_pkg::sat16(pos_sum);
               default:       pos_x_in = psg_pkg::sat16(pos_sum);
            endcase
         end
         psg_pkg::OP_SV: sv_in = sv_sum[15:0];
         psg_pkg::OP_LIFE: begin
            if (life_sum < 18'sd0) begin
               life_in = 16'd0;
            end else if (life_sum > 18'sd65535) begin
               life_in = 16'hFFFF;
            end else begin
               life_in = life_sum[15:0];
            end
         end
         psg_pkg::OP_L2_LD:  len2_in = prod_ff[49:0];
         psg_pkg::OP_L2_ADD: len2_in = len2_ff + prod_ff[49:0];
         psg_pkg::OP_DIV_START: begin
            div_axis_in = cmd.dst;
            div_neg_in  = div_n[40];
            // A near-zero direction gives no velocity at all.
            if (len2_ff <= psg_pkg::NEAR_ZERO_SQ) begin
               case (cmd.dst)
                  psg_pkg::AX_Y: vel_y_in = 16'd0;
                  psg_pkg::AX_Z: vel_z_in = 16'd0;
                  default:       vel_x_in = 16'd0;
               endcase
            end
         end
         psg_pkg::OP_EMIT: begin
            out_data_in  = {color_ff, life_ff, vel_z_ff, vel_y_ff, vel_x_ff,
                            pos_z_ff, pos_y_ff, pos_x_ff};
            out_last_in  = cmd.last;
            out_valid_in = 1'b1;
            emitted_in   = emitted_ff + 64'd1;
         end
         default: begin end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= psg_pkg::MODE_POINT;
         origin_ff    <= '0;
         extent_ff    <= '0;
         smin_ff      <= '0;
         smax_ff      <= '0;
         lmin_ff      <= '0;
         lmax_ff      <= '0;
         color_ff     <= 32'hFFFF_FFFF;
         emitted_ff   <= '0;
         rng_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         origin_ff    <= origin_in;
         extent_ff    <= extent_in;
         smin_ff      <= smin_in;
         smax_ff      <= smax_in;
         lmin_ff      <= lmin_in;
         lmax_ff      <= lmax_in;
         color_ff     <= color_in;
         emitted_ff   <= emitted_in;
         rng_ff       <= rng_in;
         out_valid_ff <= out_valid_in;
      end
      z_ff        <= z_in;
      m_ff        <= m_in;
      prod_ff     <= prod_in;
      sx_ff       <= sx_in;
      sy_ff       <= sy_in;
      sz_ff       <= sz_in;
      vx_ff       <= vx_in;
      vy_ff       <= vy_in;
      vz_ff       <= vz_in;
      st_ff       <= st_in;
      t_ff        <= t_in;
      u_ff        <= u_in;
      sv_ff       <= sv_in;
      len2_ff     <= len2_in;
      vlen_ff     <= vlen_in;
      pos_x_ff    <= pos_x_in;
      pos_y_ff    <= pos_y_in;
      pos_z_ff    <= pos_z_in;
      vel_x_ff    <= vel_x_in;
      vel_y_ff    <= vel_y_in;
      vel_z_ff    <= vel_z_in;
      life_ff     <= life_in;
      div_axis_ff <= div_axis_in;
      div_neg_ff  <= div_neg_in;
      out_data_ff <= out_data_in;
      out_last_ff <= out_last_in;
   end

   assign stat.cone      = (mode_ff == psg_pkg::MODE_CONE);
   assign stat.near_zero = (len2_ff <= psg_pkg::NEAR_ZERO_SQ);
   assign stat.unit_done = sqrt_done | div_done;
   assign stat.out_free  = !out_valid_ff || rsp_tready;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;
endmodule
`default_nettype wire

[src/psg_ctrl.sv]
// Controller: burst acceptance, particle microprogram sequencing and draw expansion.
`default_nettype none
module psg_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [6:0]           burst_count,
   input  wire psg_pkg::dp_stat_type stat,
   output psg_pkg::dp_cmd_type       cmd
);
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_DRAW = 2'd2;
   localparam logic [1:0] ST_WAIT = 2'd3;

   logic [1:0] state_ff, state_in;
   logic [5:0] pc_ff, pc_in;
   logic [3:0] ds_ff, ds_in;
   logic [6:0] count_ff, count_in;
   psg_pkg::ucode_type uc;
   logic [6:0] count_sat;

   assign uc         = psg_pkg::ucode(pc_ff);
   assign count_sat  = (burst_count > 7'(psg_pkg::MAX_BURST)) ?
                       7'(psg_pkg::MAX_BURST) : burst_count;
   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      pc_in    = pc_ff;
      ds_in    = ds_ff;
      count_in = count_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.op   = psg_pkg::OP_LOAD;
               count_in = count_sat;
               pc_in    = '0;
               if (count_sat != 7'd0) begin
                  state_in = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            if (uc.cone_only && !stat.cone) begin
               pc_in = pc_ff + 6'd1;
            end else begin
               unique case (uc.cmd.op)
                  psg_pkg::OP_DRAW: begin
                     ds_in    = '0;
                     state_in = ST_DRAW;
                  end
                  psg_pkg::OP_SQRT_START: begin
                     cmd      = uc.cmd;
                     state_in = ST_WAIT;
                  end
                  psg_pkg::OP_DIV_START: begin
                     cmd = uc.cmd;
                     if (stat.near_zero) begin
                        pc_in = pc_ff + 6'd1;
                     end else begin
                        state_in = ST_WAIT;
                     end
                  end
                  psg_pkg::OP_EMIT: begin
                     if (stat.out_free) begin
                        cmd      = uc.cmd;
                        cmd.last = (count_ff == 7'd1);
                        count_in = count_ff - 7'd1;
                        pc_in    = '0;
                        if (count_ff == 7'd1) begin
                           state_in = ST_IDLE;
                        end
                     end
                  end
                  default: begin
                     cmd   = uc.cmd;
                     pc_in = (pc_ff == psg_pkg::PC_LAST) ? 6'd0 : pc_ff + 6'd1;
                  end
               endcase
            end
         end
         ST_DRAW: begin
            cmd   = psg_pkg::draw_cmd(ds_ff, uc.cmd.dst);
            ds_in = ds_ff + 4'd1;
            if (ds_ff == psg_pkg::DRAW_LAST) begin
               pc_in    = pc_ff + 6'd1;
               state_in = ST_RUN;
            end
         end
         ST_WAIT: begin
            if (stat.unit_done) begin
               pc_in    = pc_ff + 6'd1;
               state_in = ST_RUN;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pc_ff    <= '0;
         ds_ff    <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         pc_ff    <= pc_in;
         ds_ff    <= ds_in;
         count_ff <= count_in;
      end
   end
endmodule
`default_nettype wire

[src/particle_spawn_generator.sv]
// Particle spawn generator: burst requests in, one particle word per particle out.
// Each particle is computed by eight generator draws (nine in cone mode) on the one shared 33x33
// multiplier, a square root and three divides. A near-zero direction skips the divides. A stalled
// output holds back the next particle word. A new burst is taken once the last word is in the output
// register; synchronous reset clears the control state, configuration, generator state and output
// valid flag, but not the work registers.
`default_nettype none
module particle_spawn_generator (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // [6:0] burst_count, [70:7] burst_seed, [71] zero
   input  wire logic [71:0]  req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // [15:0] pos_x, [31:16] pos_y, [47:32] pos_z, [63:48] vel_x, [79:64] vel_y,
   // [95:80] vel_z, [111:96] life_span, [143:112] rgba
   output logic [143:0]      rsp_tdata,
   output logic              rsp_tlast,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [3:0]   csr_index,
   input  wire logic [47:0]  csr_data
);
   psg_pkg::dp_cmd_type  cmd;
   psg_pkg::dp_stat_type stat;

   assign csr_ready = 1'b1;

   psg_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .burst_count (req_tdata[6:0]),
      .stat        (stat),
      .cmd         (cmd)
   );

   psg_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .seed       (req_tdata[70:7]),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );
endmodule
`default_nettype wire

[src/psg_checker.sv]
// Port-level checks for the particle spawn generator, bound to the top level.
`default_nettype none
module psg_checker (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_tvalid,
   input wire logic         req_tready,
   input wire logic [71:0]  req_tdata,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic [143:0] rsp_tdata,
   input wire logic         rsp_tlast,
   input wire logic         csr_valid,
   input wire logic         csr_ready,
   input wire logic [3:0]   csr_index,
   input wire logic [47:0]  csr_data
);
   // A stalled result word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result word changed while stalled");

   // A non-empty burst keeps the request side closed on the next cycle.
   a_busy_after_burst: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tdata[6:0] != 7'd0) |=> !req_tready)
      else $error("request taken while a burst is running");

   // A pending word that is not the last of its burst means the burst is still running.
   a_mid_burst_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("idle with a burst unfinished");

   // After reset the output is empty and a request can be taken.
   a_reset_state: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("bad state after reset");
endmodule

bind particle_spawn_generator psg_checker u_psg_checker (.*);
`default_nettype wire

[test/particle_spawn_generator_test.sv]
// Self-checking testbench for the particle spawn generator: bursts, register phases, checks.
`default_nettype none
module particle_spawn_generator_test;
   timeunit 1ns;
   timeprecision 1ps;

   // Predicts each particle word from the register settings and keeps them in order.
   class spawn_scoreboard;
      typedef struct {
         logic [143:0] word;
         logic         last;
      } particle_type;

      particle_type particles[$];
      int           errors;
      logic [1:0]   shape;
      logic [47:0]  origin;
      logic [47:0]  extent;
      logic [15:0]  speed_lo, speed_hi, life_lo, life_hi;
      logic [31:0]  color;
      logic [63:0]  emitted;
      logic [63:0]  gen;

      function new();
         errors = 0;
         shape = psg_pkg::MODE_POINT;
         origin = '0;
         extent = '0;
         speed_lo = '0;
         speed_hi = '0;
         life_lo = '0;
         life_hi = '0;
         color = 32'hFFFF_FFFF;
         emitted = '0;
         gen = '0;
      endfunction

      function void write_reg(logic [3:0] index, logic [47:0] value);
         case (index)
            psg_pkg::REG_SHAPE_MODE:  shape = value[1:0];
            psg_pkg::REG_ORIGIN_XYZ:  origin = value;
            psg_pkg::REG_EXTENT_XYZ:  extent = value;
            psg_pkg::REG_SPEED_MIN:   speed_lo = value[15:0];
            psg_pkg::REG_SPEED_MAX:   speed_hi = value[15:0];
            psg_pkg::REG_LIFE_MIN:    life_lo = value[15:0];
            psg_pkg::REG_LIFE_MAX:    life_hi = value[15:0];
            psg_pkg::REG_START_COLOR: color = value[31:0];
            default: ;
         endcase
      endfunction

      function logic [63:0] mix_next();
         logic [63:0] z;
         gen = gen + psg_pkg::GOLDEN;
         z = gen;
         z = (z ^ (z >> 30)) * psg_pkg::MIX_C1;
         z = (z ^ (z >> 27)) * psg_pkg::MIX_C2;
         return z ^ (z >> 31);
      endfunction

      function longint frac_unit();
         logic [63:0] d;
         d = mix_next();
         return longint'({40'd0, d[63:40]});
      endfunction

      function longint frac_signed();
         return frac_unit() * 2 - 64'sd16777216;
      endfunction

      function longint axis(logic [47:0] packed_xyz, int k);
         logic signed [15:0] h;
         h = packed_xyz[16*k +: 16];
         return h;
      endfunction

      function logic [15:0] clamp16(longint v);
         if (v > 32767) return 16'h7FFF;
         if (v < -32768) return 16'h8000;
         return v[15:0];
      endfunction

      function longint root_floor(longint unsigned x);
         longint unsigned r, b;
         r = 0;
         b = 64'd1 << 62;
         while (b > x) b = b >> 2;
         while (b != 0) begin
            if (x >= r + b) begin
               x = x - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
         return longint'(r);
      endfunction

      function void note_burst(logic [6:0] count, logic [63:0] seed);
         int n;
         longint s[3], off[3], v[3], t, sv, life, len2, vlen;
         particle_type p;
         n = (count > psg_pkg::MAX_BURST) ? psg_pkg::MAX_BURST : int'(count);
         gen = seed ^ emitted;
         for (int k = 0; k < n; k++) begin
            for (int i = 0; i < 3; i++) s[i] = frac_signed();
            case (shape)
               psg_pkg::MODE_BOX: begin
                  for (int i = 0; i < 3; i++) off[i] = (s[i] * axis(extent, i)) >>> 24;
               end
               psg_pkg::MODE_SPHERE: begin
                  for (int i = 0; i < 3; i++) off[i] = (s[i] * axis(extent, 0)) >>> 24;
               end
               psg_pkg::MODE_CONE: begin
                  t = frac_unit();
                  off[0] = (((s[0] * t) >>> 24) * axis(extent, 0)) >>> 24;
                  off[1] = (t * axis(extent, 1)) >>> 24;
                  off[2] = (((s[2] * t) >>> 24) * axis(extent, 0)) >>> 24;
               end
               default: begin
                  for (int i = 0; i < 3; i++) off[i] = 0;
               end
            endcase
            for (int i = 0; i < 3; i++) p.word[16*i +: 16] = clamp16(axis(origin, i) + off[i]);
            sv = longint'(speed_lo) +
                 (((longint'(speed_hi) - longint'(speed_lo)) * frac_unit()) >>> 24);
            for (int i = 0; i < 3; i++) v[i] = frac_signed();
            len2 = v[0] * v[0] + v[1] * v[1] + v[2] * v[2];
            // A direction this short carries no usable heading, so the particle stays put.
            if (len2 <= longint'(psg_pkg::NEAR_ZERO_SQ)) begin
               p.word[95:48] = '0;
            end else begin
               vlen = root_floor(len2);
               for (int i = 0; i < 3; i++) p.word[48 + 16*i +: 16] = clamp16((v[i] * sv) / vlen);
            end
            life = longint'(life_lo) +
                   (((longint'(life_hi) - longint'(life_lo)) * frac_unit()) >>> 24);
            if (life < 0) life = 0;
            if (life > 65535) life = 65535;
            p.word[111:96] = life[15:0];
            p.word[143:112] = color;
            p.last = (k + 1 == n);
            particles = {particles, p};
            emitted = emitted + 1;
         end
      endfunction

      function void check_word(logic [143:0] word, logic last);
         particle_type p;
         string names[8];
         if (particles.size() == 0) begin
            $display("%0t: unexpected particle word %h last %b", $time, word, last);
            errors++;
            return;
         end
         names = '{"pos_x", "pos_y", "pos_z", "vel_x", "vel_y", "vel_z", "life_span", "rgba"};
         p = particles.pop_front();
         for (int i = 0; i < 7; i++)
            if (word[16*i +: 16] !== p.word[16*i +: 16]) begin
               $display("%0t: %s expected %h actual %h", $time, names[i],
                        p.word[16*i +: 16], word[16*i +: 16]);
               errors++;
            end
         if (word[143:112] !== p.word[143:112]) begin
            $display("%0t: %s expected %h actual %h", $time, names[7],
                     p.word[143:112], word[143:112]);
            errors++;
         end
         if (last !== p.last) begin
            $display("%0t: last_of_burst expected %b actual %b", $time, p.last, last);
            errors++;
         end
      endfunction
   endclass

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [71:0]  req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [143:0] rsp_tdata;
   logic         rsp_tlast;
   logic         csr_valid;
   logic         csr_ready;
   logic [3:0]   csr_index;
   logic [47:0]  csr_data;

   spawn_scoreboard particle_board = new();
   int           burst_left;
   int unsigned  rx_cycle;

   particle_spawn_generator uut (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #200_000_000;
      $display("particle_spawn_generator test failed");
      $finish;
   end

   // Receiver: takes particle words and stalls in changing patterns.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) particle_board.check_word(rsp_tdata, rsp_tlast);
      rx_cycle <= rx_cycle + 1;
      case ((rx_cycle / 300) % 3)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= 1'($urandom_range(1, 0));
         default: rsp_tready <= (rx_cycle % 7) == 0;
      endcase
   end

   task automatic write_reg(logic [3:0] index, logic [47:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      particle_board.write_reg(index, value);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Sends one burst request; valid stays high so the next word can follow back to back.
   task automatic send_burst(logic [6:0] count, logic [63:0] seed);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(30, 1);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(6, 1);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata <= {1'b0, seed, count};
      do @(posedge clock); while (!req_tready);
      particle_board.note_burst(count, seed);
   endtask

   // Drops valid and waits until every predicted particle has been taken.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (particle_board.particles.size() != 0) @(posedge clock);
      // A trailing empty burst produces nothing, so give the block time to settle.
      repeat (600) @(posedge clock);
   endtask

   function automatic logic [15:0] pick_lane();
      case ($urandom_range(5, 0))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'h0000;
         3: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [6:0] pick_count();
      if ($urandom_range(40, 0) == 0) return 7'($urandom_range(127, 0));
      return 7'($urandom_range(5, 0));
   endfunction

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      burst_left = 0;
      rx_cycle = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Register defaults: point shape, zero speed and life, white color.
      send_burst(7'd0, 64'h0);
      send_burst(7'd1, 64'h0);
      send_burst(7'd2, 64'hFFFF_FFFF_FFFF_FFFF);
      send_burst(7'd127, {$urandom, $urandom});
      drain();

      // Box at the saturation corners, reversed life range, full speed range.
      write_reg(psg_pkg::REG_SHAPE_MODE, 48'(psg_pkg::MODE_BOX));
      write_reg(psg_pkg::REG_ORIGIN_XYZ, 48'h0000_8000_7FFF);
      write_reg(psg_pkg::REG_EXTENT_XYZ, 48'h7FFF_8000_7FFF);
      write_reg(psg_pkg::REG_SPEED_MIN, 48'h0);
      write_reg(psg_pkg::REG_SPEED_MAX, 48'hFFFF);
      write_reg(psg_pkg::REG_LIFE_MIN, 48'hFFFF);
      write_reg(psg_pkg::REG_LIFE_MAX, 48'h0);
      write_reg(psg_pkg::REG_START_COLOR, 48'h1234_A5C3_0F69);
      write_reg(4'd15, 48'hFFFF_FFFF_FFFF);
      send_burst(7'd64, 64'hFFFF_FFFF_FFFF_FFFF);
      send_burst(7'd3, 64'h0123_4567_89AB_CDEF);
      drain();

      // Sphere, then cone, with reversed speed range.
      write_reg(psg_pkg::REG_SHAPE_MODE, 48'(psg_pkg::MODE_SPHERE));
      write_reg(psg_pkg::REG_EXTENT_XYZ, 48'h0000_0000_8000);
      write_reg(psg_pkg::REG_SPEED_MIN, 48'hFFFF);
      write_reg(psg_pkg::REG_SPEED_MAX, 48'h0100);
      send_burst(7'd4, {$urandom, $urandom});
      drain();
      write_reg(psg_pkg::REG_SHAPE_MODE, 48'(psg_pkg::MODE_CONE));
      write_reg(psg_pkg::REG_ORIGIN_XYZ, 48'h8000_7FFF_0000);
      write_reg(psg_pkg::REG_EXTENT_XYZ, 48'h0000_7FFF_8000);
      send_burst(7'd4, {$urandom, $urandom});
      send_burst(7'd0, {$urandom, $urandom});
      send_burst(7'd3, {$urandom, $urandom});
      drain();

      for (int phase = 0; phase < 8; phase++) begin
         write_reg(psg_pkg::REG_SHAPE_MODE, 48'($urandom_range(3, 0)));
         write_reg(psg_pkg::REG_ORIGIN_XYZ, {pick_lane(), pick_lane(), pick_lane()});
         write_reg(psg_pkg::REG_EXTENT_XYZ, {pick_lane(), pick_lane(), pick_lane()});
         write_reg(psg_pkg::REG_SPEED_MIN, 48'(pick_lane()));
         write_reg(psg_pkg::REG_SPEED_MAX, 48'(pick_lane()));
         write_reg(psg_pkg::REG_LIFE_MIN, 48'(pick_lane()));
         write_reg(psg_pkg::REG_LIFE_MAX, 48'(pick_lane()));
         write_reg(psg_pkg::REG_START_COLOR, {16'($urandom), 32'($urandom)});
         if ($urandom_range(1, 0))
            write_reg(4'($urandom_range(15, 8)), {16'($urandom), 32'($urandom)});
         for (int b = 0; b < 48; b++) send_burst(pick_count(), {$urandom, $urandom});
         drain();
      end

      if (particle_board.errors == 0 && particle_board.particles.size() == 0) begin
         $display("particle_spawn_generator test passed");
      end else begin
         $display("particle_spawn_generator test failed");
      end
      $finish;
   end

endmodule
`default_nettype wire
